@@ src/brgb_pkg.sv @@
// shared types, constants and the light-to-interval mapping for the breathing rgb led controller
`default_nettype none

package brgb_pkg;

   localparam int DUTY_BITS_DEF = 12;
   localparam int CFG_BITS      = 10;
   localparam int CNT_BITS      = 10;
   localparam int IVL_BITS      = 6;
   localparam int LIGHT_BITS    = 12;
   localparam int ADDR_BITS     = 4;
   localparam int DATA_BITS     = 32;

   localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;
   localparam logic [LIGHT_BITS-1:0] LIGHT_LO  = 12'd200;
   localparam logic [LIGHT_BITS-1:0] LIGHT_HI  = 12'd3000;
   localparam logic [IVL_BITS-1:0]   IVL_SLOW  = 6'd60;
   localparam logic [IVL_BITS-1:0]   IVL_FAST  = 6'd5;
   localparam logic [IVL_BITS-1:0]   IVL_RESET = 6'd20;

   // floor(d*55/2800) == (d * 55 * ceil(2^30/2800)) >> 30 for every d in 0..2800
   localparam int              IVL_SHIFT = 30;
   localparam int              PROD_BITS = 37;
   localparam logic [PROD_BITS-1:0] IVL_RECIP = 37'd21091400;

   localparam logic [CFG_BITS-1:0] FADE_STEP_RESET     = 10'd20;
   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET      = 10'd50;
   localparam logic [CFG_BITS-1:0] SENSOR_PERIOD_RESET = 10'd300;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_FADE_STEP     = 2'd0;
   localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
   localparam logic [1:0] REG_SENSOR_PERIOD = 2'd2;

   localparam logic [1:0] COLOUR_RED   = 2'd0;
   localparam logic [1:0] COLOUR_GREEN = 2'd1;
   localparam logic [1:0] COLOUR_BLUE  = 2'd2;

   typedef struct packed {
      logic [CFG_BITS-1:0] fade_step;
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] sensor_period_ms;
   } cfg_type;

   function automatic logic [IVL_BITS-1:0] light_to_interval(input logic [LIGHT_BITS-1:0] light);
      logic [LIGHT_BITS-1:0] clamped;
      logic [LIGHT_BITS-1:0] offset;
      logic [PROD_BITS-1:0]  prod;
      logic [IVL_BITS-1:0]   quot;
      if (light < LIGHT_LO) begin
         clamped = LIGHT_LO;
      end else if (light > LIGHT_HI) begin
         clamped = LIGHT_HI;
      end else begin
         clamped = light;
      end
      offset = clamped - LIGHT_LO;
      prod   = PROD_BITS'(offset) * IVL_RECIP;
      quot   = prod[IVL_SHIFT+IVL_BITS-1:IVL_SHIFT];
      return IVL_SLOW - quot;
   endfunction

endpackage

`default_nettype wire

@@ src/brgb_csr.sv @@
// configuration registers behind the apb-style port
`default_nettype none

module brgb_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [brgb_pkg::ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [brgb_pkg::DATA_BITS-1:0]     csr_pwdata,
   output logic      [brgb_pkg::DATA_BITS-1:0]     csr_prdata,
   output logic                                    csr_pready,
   output brgb_pkg::cfg_type                       cfg
);

   brgb_pkg::cfg_type cfg_ff;
   brgb_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            brgb_pkg::REG_FADE_STEP:
               cfg_in.fade_step = csr_pwdata[brgb_pkg::CFG_BITS-1:0];
            brgb_pkg::REG_DEBOUNCE:
               cfg_in.debounce_ms = csr_pwdata[brgb_pkg::CFG_BITS-1:0];
            brgb_pkg::REG_SENSOR_PERIOD:
               cfg_in.sensor_period_ms = csr_pwdata[brgb_pkg::CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         brgb_pkg::REG_FADE_STEP:
            csr_prdata = brgb_pkg::DATA_BITS'(cfg_ff.fade_step);
         brgb_pkg::REG_DEBOUNCE:
            csr_prdata = brgb_pkg::DATA_BITS'(cfg_ff.debounce_ms);
         brgb_pkg::REG_SENSOR_PERIOD:
            csr_prdata = brgb_pkg::DATA_BITS'(cfg_ff.sensor_period_ms);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_step        <= brgb_pkg::FADE_STEP_RESET;
         cfg_ff.debounce_ms      <= brgb_pkg::DEBOUNCE_RESET;
         cfg_ff.sensor_period_ms <= brgb_pkg::SENSOR_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/breathing_rgb_led_controller.sv @@
// top level of the breathing rgb led controller: tick pipeline, debounce, breathing state
//
// Each request is one millisecond tick carrying the raw button level and a light
// sample; every request yields exactly one response with the three duty values,
// the current pass interval and a flag telling whether a breathing pass ran.
// Requests enter on req_valid/req_stall, responses leave on rsp_valid/rsp_stall;
// a transfer happens on a clock edge with valid high and stall low.
// A request lands in an input register; when the response register can advance,
// the debounce, colour, pass and interval logic runs in one step and the response
// register loads, and the response is offered from it. One request is taken every
// cycle unless the receiver stalls; the state update in that single step sets the rate.
// While the receiver stalls, the response holds and one more request can still
// be taken into the input register; after that req_stall rises until the
// response moves on.
// Synchronous reset empties both registers and puts the breathing state back:
// red selected, level zero and rising, interval 20 ms, the first tick runs a
// pass, configuration back to step 20, debounce 50 ms and sensor period 300 ms.
// Users must write configuration via csr_ only with no request in flight; not enforced.
`default_nettype none

module breathing_rgb_led_controller #(
   parameter int DUTY_BITS = brgb_pkg::DUTY_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_button_level,
   input  wire logic [brgb_pkg::LIGHT_BITS-1:0]     req_light_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [DUTY_BITS-1:0]                rsp_red_duty,
   output logic      [DUTY_BITS-1:0]                rsp_green_duty,
   output logic      [DUTY_BITS-1:0]                rsp_blue_duty,
   output logic      [brgb_pkg::IVL_BITS-1:0]       rsp_pass_interval,
   output logic                                     rsp_pass_ran,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [brgb_pkg::ADDR_BITS-1:0]      csr_paddr,
   input  wire logic [brgb_pkg::DATA_BITS-1:0]      csr_pwdata,
   output logic      [brgb_pkg::DATA_BITS-1:0]      csr_prdata,
   output logic                                     csr_pready
);

   localparam int LVL_BITS = ((DUTY_BITS > brgb_pkg::CNT_BITS) ? DUTY_BITS
                                                               : brgb_pkg::CNT_BITS) + 1;
   localparam logic [LVL_BITS-1:0] FULL_SCALE = LVL_BITS'((2 ** DUTY_BITS) - 1);

   localparam int CB = brgb_pkg::CNT_BITS;
   localparam int IB = brgb_pkg::IVL_BITS;

   brgb_pkg::cfg_type cfg;

   brgb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   logic                            in_valid_ff;
   logic                            in_button_ff;
   logic [brgb_pkg::LIGHT_BITS-1:0] in_light_ff;

   // breathing state
   logic [IB-1:0]       wait_left_ff,    wait_left_in;
   logic [IB-1:0]       interval_ff,     interval_in;
   logic [CB-1:0]       since_sensor_ff, since_sensor_in;
   logic                raw_prev_ff;
   logic                stable_ff,       stable_in;
   logic [CB-1:0]       hold_ff,         hold_in;
   logic [1:0]          colour_ff,       colour_in;
   logic [LVL_BITS-1:0] level_ff,        level_in;
   logic                down_ff,         down_in;

   // response register
   logic                 rsp_valid_ff;
   logic [DUTY_BITS-1:0] red_ff,   red_in;
   logic [DUTY_BITS-1:0] green_ff, green_in;
   logic [DUTY_BITS-1:0] blue_ff,  blue_in;
   logic [IB-1:0]        ivl_out_ff;
   logic                 ran_ff,   ran_in;

   logic                 advance;
   logic                 step_en;
   logic [LVL_BITS-1:0]  step_ext;
   logic [LVL_BITS-1:0]  level_step;
   logic [DUTY_BITS-1:0] duty;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign step_ext  = LVL_BITS'(cfg.fade_step);

   always_comb begin
      hold_in         = hold_ff;
      stable_in       = stable_ff;
      colour_in       = colour_ff;
      since_sensor_in = since_sensor_ff;
      interval_in     = interval_ff;
      level_in        = level_ff;
      down_in         = down_ff;
      wait_left_in    = wait_left_ff;
      ran_in          = 1'b0;
      level_step      = level_ff;

      // debounce
      if (in_button_ff != raw_prev_ff) begin
         hold_in = '0;
      end else if (hold_ff != brgb_pkg::CNT_MAX) begin
         hold_in = hold_ff + CB'(1);
      end
      if (hold_in > cfg.debounce_ms && in_button_ff != stable_ff) begin
         stable_in = in_button_ff;
         // falling edge of the stable level steps the colour
         if (!in_button_ff) begin
            colour_in = (colour_ff >= brgb_pkg::COLOUR_BLUE) ? brgb_pkg::COLOUR_RED
                                                             : colour_ff + 2'd1;
         end
      end

      if (since_sensor_ff != brgb_pkg::CNT_MAX) begin
         since_sensor_in = since_sensor_ff + CB'(1);
      end

      if (wait_left_ff == '0) begin
         ran_in = 1'b1;
         if (down_ff) begin
            level_step = (step_ext >= level_ff) ? '0 : level_ff - step_ext;
         end else begin
            level_step = level_ff + step_ext;
         end
         level_in = level_step;
         if (level_step >= FULL_SCALE) begin
            down_in = 1'b1;
         end
         if (level_step == '0) begin
            down_in = 1'b0;
         end
         if (since_sensor_in > cfg.sensor_period_ms) begin
            interval_in     = brgb_pkg::light_to_interval(in_light_ff);
            since_sensor_in = '0;
         end
         wait_left_in = interval_in - IB'(1);
      end else begin
         wait_left_in = wait_left_ff - IB'(1);
      end

      duty     = (level_in > FULL_SCALE) ? FULL_SCALE[DUTY_BITS-1:0]
                                         : level_in[DUTY_BITS-1:0];
      red_in   = '0;
      green_in = '0;
      blue_in  = '0;
      unique case (colour_in)
         brgb_pkg::COLOUR_RED:   red_in   = duty;
         brgb_pkg::COLOUR_GREEN: green_in = duty;
         brgb_pkg::COLOUR_BLUE:  blue_in  = duty;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         wait_left_ff    <= '0;
         interval_ff     <= brgb_pkg::IVL_RESET;
         since_sensor_ff <= '0;
         raw_prev_ff     <= 1'b1;
         stable_ff       <= 1'b1;
         hold_ff         <= '0;
         colour_ff       <= brgb_pkg::COLOUR_RED;
         level_ff        <= '0;
         down_ff         <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (step_en) begin
            wait_left_ff    <= wait_left_in;
            interval_ff     <= interval_in;
            since_sensor_ff <= since_sensor_in;
            raw_prev_ff     <= in_button_ff;
            stable_ff       <= stable_in;
            hold_ff         <= hold_in;
            colour_ff       <= colour_in;
            level_ff        <= level_in;
            down_ff         <= down_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_button_ff <= req_button_level;
         in_light_ff  <= req_light_sample;
      end
      if (step_en) begin
         red_ff     <= red_in;
         green_ff   <= green_in;
         blue_ff    <= blue_in;
         ivl_out_ff <= interval_in;
         ran_ff     <= ran_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_duty      = red_ff;
   assign rsp_green_duty    = green_ff;
   assign rsp_blue_duty     = blue_ff;
   assign rsp_pass_interval = ivl_out_ff;
   assign rsp_pass_ran      = ran_ff;

   // a shown pass reloads the wait counter from the interval it reports
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ran_ff |-> wait_left_ff == ivl_out_ff - IB'(1))
      else $error("wait counter not reloaded from pass interval");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ivl_out_ff >= brgb_pkg::IVL_FAST && ivl_out_ff <= brgb_pkg::IVL_SLOW)
      else $error("pass interval out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({red_ff != '0, green_ff != '0, blue_ff != '0}) <= 1)
      else $error("more than one colour lit");

   assert property (@(posedge clock) disable iff (reset)
      colour_ff != 2'd3)
      else $error("unused colour selected");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && in_valid_ff)
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire
